### rtl/core/wle_pkg.sv
// Package for the wavetable LFO evaluator.
// Shared field widths, register index and waveform codes, configuration struct.
// No dependencies.
package wle_pkg;

  localparam int ValueWidth = 24;
  localparam int TimeWidth  = 32;
  localparam int WaveWidth  = 3;
  localparam int IndexWidth = 3;

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef enum logic [WaveWidth-1:0] {
    WAVE_ONE        = 3'd0,
    WAVE_NOISE      = 3'd1,
    WAVE_NOISE_LERP = 3'd2,
    WAVE_SQUARE     = 3'd3,
    WAVE_SAW        = 3'd4,
    WAVE_ISAW       = 3'd5,
    WAVE_SINE       = 3'd6,
    WAVE_TRI        = 3'd7
  } wave_t;

  typedef enum logic [IndexWidth-1:0] {
    REG_WAVEFORM     = 3'd0,
    REG_FREQUENCY    = 3'd1,
    REG_PHASE_OFFSET = 3'd2,
    REG_AMPLITUDE    = 3'd3,
    REG_OFFSET_BASE  = 3'd4,
    REG_CLAMP_HIGH   = 3'd5,
    REG_CLAMP_LOW    = 3'd6
  } reg_index_t;

  typedef struct packed {
    wave_t  waveform;
    value_t frequency;
    value_t phase_offset;
    value_t amplitude;
    value_t offset_base;
    value_t clamp_high;
    value_t clamp_low;
  } cfg_t;

  typedef struct packed {
    logic adv;
  } pipe_ctl_t;

endpackage

### rtl/core/wle_phase.sv
// Phase stages: frequency times time, add offset, take magnitude, scale by entries - 1.
// Produces the table index and the signed fraction. Depends on wle_pkg.
module wle_phase import wle_pkg::*; #(
  parameter int TABLE_ENTRIES = 512,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pipe_ctl_t                       ctl,
  input  logic                            in_vld,
  input  logic [TimeWidth-1:0]            in_time,
  input  value_t                          frequency,
  input  value_t                          phase_offset,
  output logic                            out_vld,
  output logic [$clog2(TABLE_ENTRIES)-1:0] out_idx,
  output logic signed [FRACTION_BITS:0]   out_frac
);

  localparam int L     = $clog2(TABLE_ENTRIES);
  localparam int F     = FRACTION_BITS;
  localparam int ProdW = ValueWidth + TimeWidth + 1;
  localparam int SumW  = ProdW + 1;
  localparam int MulW  = SumW + L;

  logic [3:0] vld_r;

  logic signed [ProdW-1:0] s1_prod_nxt, s1_prod_r;
  logic signed [SumW-1:0]  s2_p_nxt, s2_p_r;
  logic [SumW-1:0]         s3_mag_nxt, s3_mag_r;
  logic                    s3_neg_r;
  logic [MulW-1:0]         scaled;
  logic [L-1:0]            ip;
  logic [F-1:0]            fr;
  logic [L-1:0]            s4_idx_nxt, s4_idx_r;
  logic signed [F:0]       s4_frac_nxt, s4_frac_r;

  assign s1_prod_nxt = ProdW'(frequency) * ProdW'($signed({1'b0, in_time}));
  assign s2_p_nxt    = SumW'(s1_prod_r) + (SumW'(phase_offset) <<< F);
  assign s3_mag_nxt  = s2_p_r[SumW-1] ? SumW'(-s2_p_r) : SumW'(s2_p_r);

  assign scaled      = (MulW'(s3_mag_r) << L) - MulW'(s3_mag_r);
  assign ip          = scaled[2*F +: L];
  assign fr          = scaled[F +: F];
  assign s4_idx_nxt  = s3_neg_r ? L'(-ip) : ip;
  assign s4_frac_nxt = s3_neg_r ? -$signed({1'b0, fr}) : $signed({1'b0, fr});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s1_prod_r <= s1_prod_nxt;
      s2_p_r    <= s2_p_nxt;
      s3_mag_r  <= s3_mag_nxt;
      s3_neg_r  <= s2_p_r[SumW-1];
      s4_idx_r  <= s4_idx_nxt;
      s4_frac_r <= s4_frac_nxt;
    end
  end

  assign out_vld  = vld_r[3];
  assign out_idx  = s4_idx_r;
  assign out_frac = s4_frac_r;

endmodule

### rtl/core/wle_rom.sv
// Waveform tables built at elaboration and the registered table read.
// Selects the sample pair by waveform code. Depends on wle_pkg.
module wle_rom import wle_pkg::*; #(
  parameter int TABLE_ENTRIES = 512,
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pipe_ctl_t                        ctl,
  input  logic                             in_vld,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] in_idx,
  input  logic signed [FRACTION_BITS:0]    in_frac,
  input  wave_t                            waveform,
  output logic                             out_vld,
  output logic [FRACTION_BITS:0]           out_v0,
  output logic [FRACTION_BITS:0]           out_v1,
  output logic signed [FRACTION_BITS:0]    out_frac
);

  localparam int L    = $clog2(TABLE_ENTRIES);
  localparam int F    = FRACTION_BITS;
  localparam int W    = F + 1;
  localparam int N    = TABLE_ENTRIES;
  localparam longint unsigned Last    = longint'(TABLE_ENTRIES - 1);
  localparam longint unsigned Half    = longint'(TABLE_ENTRIES / 2);
  localparam longint unsigned One     = longint'(1) << FRACTION_BITS;
  localparam longint unsigned HalfPi  = 64'd1686629713;

  typedef logic [W-1:0] tab_t [N];

  function automatic tab_t build_noise();
    tab_t t;
    logic [31:0] lcg;
    longint unsigned s;
    lcg = 32'h12345678;
    for (int i = 0; i < N; i++) begin
      s    = longint'(lcg[15:0]);
      lcg  = 32'(32'd69069 * lcg + 32'd41);
      t[i] = W'(((s << F) + 64'd32767) / 64'd65535);
    end
    return t;
  endfunction

  function automatic tab_t build_saw(bit inverse);
    tab_t t;
    longint unsigned k;
    for (int i = 0; i < N; i++) begin
      k    = inverse ? Last - longint'(i) : longint'(i);
      t[i] = W'(((k << F) + Last / 64'd2) / Last);
    end
    return t;
  endfunction

  function automatic tab_t build_square();
    tab_t t;
    for (int i = 0; i < N; i++) begin
      t[i] = (longint'(i) < Half) ? W'(One) : '0;
    end
    return t;
  endfunction

  function automatic tab_t build_tri();
    tab_t t;
    longint unsigned k;
    for (int i = 0; i < N; i++) begin
      k = longint'(i);
      t[i] = (k < Half) ? W'((k << F) / Half) : W'(One - (((k - Half) << F) / Half));
    end
    return t;
  endfunction

  function automatic longint unsigned quarter_sine(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x    = (r * HalfPi) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  function automatic tab_t build_sine();
    tab_t t;
    longint unsigned u;
    longint unsigned q;
    longint unsigned r;
    longint sv;
    longint e;
    for (int i = 0; i < N; i++) begin
      u = (longint'(i) << 32) / Last;
      q = (u >> 30) & 64'd3;
      r = u & 64'h3FFF_FFFF;
      if (q[0]) begin
        r = 64'h4000_0000 - r;
      end
      sv = longint'((quarter_sine(r) + (64'd1 << (30 - F))) >> (31 - F));
      e  = (q < 64'd2) ? longint'(One / 64'd2) + sv : longint'(One / 64'd2) - sv;
      if (e < 0) begin
        e = 0;
      end
      if (e > longint'(One)) begin
        e = longint'(One);
      end
      t[i] = W'(e);
    end
    return t;
  endfunction

  localparam tab_t NoiseTab  = build_noise();
  localparam tab_t SawTab    = build_saw(1'b0);
  localparam tab_t IsawTab   = build_saw(1'b1);
  localparam tab_t SquareTab = build_square();
  localparam tab_t TriTab    = build_tri();
  localparam tab_t SineTab   = build_sine();

  logic [L-1:0]       idx_next;
  logic [W-1:0]       v0_nxt, v1_nxt, v0_r, v1_r;
  logic signed [F:0]  frac_r;
  logic               vld_r;

  assign idx_next = L'(in_idx + 1'b1);

  always_comb begin
    v0_nxt = W'(One);
    case (waveform)
      WAVE_NOISE, WAVE_NOISE_LERP: v0_nxt = NoiseTab[in_idx];
      WAVE_SQUARE:                 v0_nxt = SquareTab[in_idx];
      WAVE_SAW:                    v0_nxt = SawTab[in_idx];
      WAVE_ISAW:                   v0_nxt = IsawTab[in_idx];
      WAVE_SINE:                   v0_nxt = SineTab[in_idx];
      WAVE_TRI:                    v0_nxt = TriTab[in_idx];
      default:                     v0_nxt = W'(One);
    endcase
    v1_nxt = (waveform == WAVE_NOISE_LERP) ? NoiseTab[idx_next] : v0_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      v0_r   <= v0_nxt;
      v1_r   <= v1_nxt;
      frac_r <= in_frac;
    end
  end

  assign out_vld  = vld_r;
  assign out_v0   = v0_r;
  assign out_v1   = v1_r;
  assign out_frac = frac_r;

endmodule

### rtl/core/wle_shape.sv
// Output stages: interpolate, apply gain and offset, clamp, saturate, output register.
// Depends on wle_pkg.
module wle_shape import wle_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pipe_ctl_t                     ctl,
  input  logic                          in_vld,
  input  logic [FRACTION_BITS:0]        in_v0,
  input  logic [FRACTION_BITS:0]        in_v1,
  input  logic signed [FRACTION_BITS:0] in_frac,
  input  value_t                        amplitude,
  input  value_t                        offset_base,
  input  value_t                        clamp_high,
  input  value_t                        clamp_low,
  output logic                          out_vld,
  output value_t                        out_value
);

  localparam int F   = FRACTION_BITS;
  localparam int W   = F + 1;
  localparam int DW  = W + 1;
  localparam int DPW = DW + F + 1;
  localparam int VW  = F + 3;
  localparam int MW  = ValueWidth + VW;
  localparam int OW  = ValueWidth + 4;

  localparam logic signed [OW-1:0] SatHi = OW'($signed(24'h7FFFFF));
  localparam logic signed [OW-1:0] SatLo = OW'($signed(24'h800000));

  logic [4:0] vld_r;

  logic signed [DW-1:0]  diff;
  logic signed [DPW-1:0] s5_dp_nxt, s5_dp_r;
  logic [W-1:0]          s5_v0_r;
  logic signed [VW-1:0]  s6_v_nxt, s6_v_r;
  logic signed [MW-1:0]  s7_m_nxt, s7_m_r;
  logic signed [OW-1:0]  s8_o_nxt, s8_o_r;
  logic signed [OW-1:0]  hi, lo, clamped;
  value_t                value_nxt, value_r;

  assign diff      = $signed({1'b0, in_v1}) - $signed({1'b0, in_v0});
  assign s5_dp_nxt = DPW'(diff) * DPW'(in_frac);
  assign s6_v_nxt  = VW'($signed({1'b0, s5_v0_r})) + VW'(s5_dp_r >>> F);
  assign s7_m_nxt  = MW'(amplitude) * MW'(s6_v_r);
  assign s8_o_nxt  = OW'(s7_m_r >>> F) + OW'(offset_base);

  assign hi = OW'(clamp_high);
  assign lo = OW'(clamp_low);

  always_comb begin
    clamped = s8_o_r;
    if (clamped >= hi) begin
      clamped = hi;
    end
    if (clamped < lo) begin
      clamped = lo;
    end
    if (clamped > SatHi) begin
      value_nxt = ValueWidth'(SatHi);
    end else if (clamped < SatLo) begin
      value_nxt = ValueWidth'(SatLo);
    end else begin
      value_nxt = ValueWidth'(clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s5_dp_r <= s5_dp_nxt;
      s5_v0_r <= in_v0;
      s6_v_r  <= s6_v_nxt;
      s7_m_r  <= s7_m_nxt;
      s8_o_r  <= s8_o_nxt;
      value_r <= value_nxt;
    end
  end

  assign out_vld   = vld_r[4];
  assign out_value = value_r;

endmodule

### rtl/core/wavetable_lfo_evaluator.sv
// Top level of the wavetable LFO evaluator: configuration registers and stage chain.
// Instantiates wle_phase, wle_rom and wle_shape; depends on wle_pkg.
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_stall    in_time_value
//   out_     result     out_valid / out_stall  out_wave_value
//   cfg_     write      cfg_write_en           cfg_index, cfg_wdata
//
// One request per cycle while in_stall is low.
// The chain has ten register stages that move together; all hold while a
// result waits at the output register under out_stall.
// Synchronous active-low reset clears valid bits and loads register defaults.
module wavetable_lfo_evaluator import wle_pkg::*; #(
  parameter int TABLE_ENTRIES = 512,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TimeWidth-1:0]  in_time_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output value_t                out_wave_value,
  input  logic                  cfg_write_en,
  input  logic [IndexWidth-1:0] cfg_index,
  input  logic [ValueWidth-1:0] cfg_wdata
);

  localparam int L = $clog2(TABLE_ENTRIES);
  localparam int F = FRACTION_BITS;

  cfg_t      cfg_r, cfg_nxt;
  pipe_ctl_t ctl;

  logic                phase_vld;
  logic [L-1:0]        phase_idx;
  logic signed [F:0]   phase_frac;
  logic                rom_vld;
  logic [F:0]          rom_v0, rom_v1;
  logic signed [F:0]   rom_frac;

  assign ctl.adv  = !(out_valid && out_stall);
  assign in_stall = !ctl.adv;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_WAVEFORM:     cfg_nxt.waveform     = wave_t'(cfg_wdata[WaveWidth-1:0]);
        REG_FREQUENCY:    cfg_nxt.frequency    = cfg_wdata;
        REG_PHASE_OFFSET: cfg_nxt.phase_offset = cfg_wdata;
        REG_AMPLITUDE:    cfg_nxt.amplitude    = cfg_wdata;
        REG_OFFSET_BASE:  cfg_nxt.offset_base  = cfg_wdata;
        REG_CLAMP_HIGH:   cfg_nxt.clamp_high   = cfg_wdata;
        REG_CLAMP_LOW:    cfg_nxt.clamp_low    = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waveform     <= WAVE_ONE;
      cfg_r.frequency    <= ValueWidth'(1 << F);
      cfg_r.phase_offset <= '0;
      cfg_r.amplitude    <= ValueWidth'(1 << F);
      cfg_r.offset_base  <= '0;
      cfg_r.clamp_high   <= 24'sh7FFFFF;
      cfg_r.clamp_low    <= -24'sh800000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wle_phase #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .in_vld       (in_valid),
    .in_time      (in_time_value),
    .frequency    (cfg_r.frequency),
    .phase_offset (cfg_r.phase_offset),
    .out_vld      (phase_vld),
    .out_idx      (phase_idx),
    .out_frac     (phase_frac)
  );

  wle_rom #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_rom (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_vld   (phase_vld),
    .in_idx   (phase_idx),
    .in_frac  (phase_frac),
    .waveform (cfg_r.waveform),
    .out_vld  (rom_vld),
    .out_v0   (rom_v0),
    .out_v1   (rom_v1),
    .out_frac (rom_frac)
  );

  wle_shape #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_shape (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_vld      (rom_vld),
    .in_v0       (rom_v0),
    .in_v1       (rom_v1),
    .in_frac     (rom_frac),
    .amplitude   (cfg_r.amplitude),
    .offset_base (cfg_r.offset_base),
    .clamp_high  (cfg_r.clamp_high),
    .clamp_low   (cfg_r.clamp_low),
    .out_vld     (out_valid),
    .out_value   (out_wave_value)
  );

`ifndef SYNTHESIS
  a_stall_holds_stages: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable({phase_vld, rom_vld}))
    else $error("stage valid bits moved while the output was stalled");

  a_no_result_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("request stalled with an empty output register");

  a_free_pipe_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_stall && phase_vld) |=> rom_vld)
    else $error("request lost between phase and table stages");
`endif

endmodule
